/* sv/polyline_arc_length_resampler_unit_assert.svh */
// Assertion macros used by the checker file.
`ifndef POLYLINE_ARC_LENGTH_RESAMPLER_UNIT_ASSERT_SVH
`define POLYLINE_ARC_LENGTH_RESAMPLER_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PLAR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("plar checker: same-cycle property failed");

// Consequent must hold in the cycle after the antecedent.
`define PLAR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("plar checker: next-cycle property failed");

`endif

/* sv/plar_pkg.sv */
`default_nettype none

package plar_pkg;

    localparam int MAX_OUT_DEFAULT    = 64;
    localparam int MAX_OUT_LIMIT      = 64;
    localparam int COORD_BITS_DEFAULT = 16;

    localparam int C_W      = 16;   // coordinate width
    localparam int IV_W     = 15;   // interval width
    localparam int LEN_W    = 17;   // edge length width
    localparam int SQ_W     = 33;   // squared length width
    localparam int NUM_W    = 32;   // divider numerator width
    localparam int Q_W      = 17;   // divider quotient width
    localparam int RAW_W    = 18;   // unclipped sample count width
    localparam int JOB_CNT_W = $clog2(MAX_OUT_LIMIT + 1);
    localparam int FIFO_DEPTH = 2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_STEP_INTERVAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTRE_X      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CENTRE_Y      = 2'd2;

    localparam logic [IV_W-1:0] STEP_INTERVAL_RESET = 15'd272;

    // One edge (or one lone start point) to be walked by the back end.
    typedef struct packed {
        logic signed [C_W-1:0] px;
        logic signed [C_W-1:0] py;
        logic                  negx;
        logic                  negy;
        logic [Q_W-1:0]        qx;
        logic [LEN_W-1:0]      rx;
        logic [Q_W-1:0]        bx;
        logic [LEN_W-1:0]      rbx;
        logic [Q_W-1:0]        qy;
        logic [LEN_W-1:0]      ry;
        logic [Q_W-1:0]        by;
        logic [LEN_W-1:0]      rby;
        logic [LEN_W-1:0]      len;
        logic [JOB_CNT_W-1:0]  cnt;
        logic                  last;
        logic                  trunc;
    } job_t;

endpackage

`default_nettype wire

/* sv/plar_sqrt.sv */
`default_nettype none

// Integer square root, one result bit per cycle.
module plar_sqrt (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [plar_pkg::SQ_W-1:0]    radicand,
    output logic                              done,
    output logic [plar_pkg::LEN_W-1:0]        root
);

    localparam int RAD_W = 2 * plar_pkg::LEN_W;
    localparam int REM_W = plar_pkg::LEN_W + 2;
    localparam int CNT_W = $clog2(plar_pkg::LEN_W + 1);

    logic [RAD_W-1:0]          rad_reg;
    logic [REM_W-1:0]          rem_reg;
    logic [plar_pkg::LEN_W-1:0] root_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic                      done_reg;
    logic [REM_W+1:0]          t;
    logic [REM_W+1:0]          trial;
    logic                      fits;

    assign t     = {rem_reg, rad_reg[RAD_W-1 -: 2]};
    assign trial = {2'b00, root_reg, 2'b01};
    assign fits  = (t >= trial);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= (cnt_reg == CNT_W'(1));
            if (start) begin
                cnt_reg <= CNT_W'(plar_pkg::LEN_W);
            end else if (cnt_reg != '0) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk) begin
        if (start) begin
            rad_reg  <= {{(RAD_W - plar_pkg::SQ_W){1'b0}}, radicand};
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (cnt_reg != '0) begin
            rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
            rem_reg  <= fits ? REM_W'(t - trial) : t[REM_W-1:0];
            root_reg <= {root_reg[plar_pkg::LEN_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

/* sv/plar_div.sv */
`default_nettype none

// Restoring divider, one quotient bit per cycle. The numerator shifted right by
// the quotient width must be below the denominator.
module plar_div (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [plar_pkg::NUM_W-1:0]   num,
    input  wire logic [plar_pkg::LEN_W-1:0]   den,
    output logic                              done,
    output logic [plar_pkg::Q_W-1:0]          quo,
    output logic [plar_pkg::LEN_W-1:0]        rem
);

    localparam int CNT_W = $clog2(plar_pkg::Q_W + 1);

    logic [plar_pkg::LEN_W-1:0] den_reg;
    logic [plar_pkg::LEN_W-1:0] pr_reg;
    logic [plar_pkg::Q_W-1:0]   nsh_reg;
    logic [plar_pkg::Q_W-1:0]   q_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic                       done_reg;
    logic [plar_pkg::LEN_W:0]   t;
    logic                       fits;

    assign t    = {pr_reg, nsh_reg[plar_pkg::Q_W-1]};
    assign fits = (t >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= (cnt_reg == CNT_W'(1));
            if (start) begin
                cnt_reg <= CNT_W'(plar_pkg::Q_W);
            end else if (cnt_reg != '0) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk) begin
        if (start) begin
            den_reg <= den;
            pr_reg  <= plar_pkg::LEN_W'(num[plar_pkg::NUM_W-1:plar_pkg::Q_W]);
            nsh_reg <= num[plar_pkg::Q_W-1:0];
            q_reg   <= '0;
        end else if (cnt_reg != '0) begin
            pr_reg  <= fits ? plar_pkg::LEN_W'(t - {1'b0, den_reg})
                            : t[plar_pkg::LEN_W-1:0];
            nsh_reg <= {nsh_reg[plar_pkg::Q_W-2:0], 1'b0};
            q_reg   <= {q_reg[plar_pkg::Q_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quo  = q_reg;
    assign rem  = pr_reg;

endmodule

`default_nettype wire

/* sv/plar_front.sv */
`default_nettype none

// Front end: takes a vertex, measures its edges, counts their samples and
// prepares the interpolation steps, then queues one job per emitting edge or start point.
module plar_front #(
    parameter int MAX_OUT = plar_pkg::MAX_OUT_DEFAULT
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              vertex_valid,
    output logic                                   vertex_ready,
    input  wire logic signed [plar_pkg::C_W-1:0]   vertex_x,
    input  wire logic signed [plar_pkg::C_W-1:0]   vertex_y,
    input  wire logic                              begins_subpath,
    input  wire logic                              closes_subpath,
    input  wire logic [plar_pkg::IV_W-1:0]         step_interval,
    output logic                                   push,
    output plar_pkg::job_t                         job,
    input  wire logic                              full
);

    localparam int C_W   = plar_pkg::C_W;
    localparam int L_W   = plar_pkg::LEN_W;
    localparam int IV_W  = plar_pkg::IV_W;
    localparam int R_W   = plar_pkg::RAW_W;
    localparam int N_W   = plar_pkg::NUM_W;
    localparam int CN_W  = plar_pkg::JOB_CNT_W;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_EDGE = 4'd1;
    localparam logic [3:0] S_MX   = 4'd2;
    localparam logic [3:0] S_MY   = 4'd3;
    localparam logic [3:0] S_SQ   = 4'd4;
    localparam logic [3:0] S_SQW  = 4'd5;
    localparam logic [3:0] S_QDW  = 4'd6;
    localparam logic [3:0] S_FIN  = 4'd7;
    localparam logic [3:0] S_JOB  = 4'd8;
    localparam logic [3:0] S_JMUL = 4'd9;
    localparam logic [3:0] S_JDIV = 4'd10;
    localparam logic [3:0] S_JDW  = 4'd11;
    localparam logic [3:0] S_PUSH = 4'd12;

    logic [3:0] st_reg;
    logic       beg_reg;
    logic       cls_reg;
    logic       k_reg;
    logic       j_reg;
    logic [1:0] ph_reg;
    logic       trunc_reg;

    logic signed [C_W-1:0] tx_reg, ty_reg;
    logic signed [C_W-1:0] prev_x_reg, prev_y_reg;
    logic signed [C_W-1:0] start_x_reg, start_y_reg;
    logic [C_W-1:0]        carry_reg;

    logic signed [C_W-1:0] e_px_reg  [2];
    logic signed [C_W-1:0] e_py_reg  [2];
    logic [C_W-1:0]        e_adx_reg [2];
    logic [C_W-1:0]        e_ady_reg [2];
    logic                  e_nx_reg  [2];
    logic                  e_ny_reg  [2];
    logic [L_W-1:0]        e_len_reg [2];
    logic [IV_W-1:0]       e_pos_reg [2];
    logic [R_W-1:0]        e_cnt_reg [2];
    logic [CN_W-1:0]       emit_reg  [2];

    logic [plar_pkg::Q_W-1:0] res_q_reg [4];
    logic [L_W-1:0]           res_r_reg [4];

    logic [N_W-1:0]            prod_reg;
    logic [plar_pkg::SQ_W-1:0] sq_reg;

    logic            eidx;
    logic [IV_W-1:0] iv;
    logic [C_W:0]    dx, dy;
    logic [C_W-1:0]  adx_c, ady_c;
    logic [IV_W-1:0] pos_c;
    logic [C_W-1:0]  mul_a, mul_b;
    logic [N_W-1:0]  mul_p;
    logic            sq_start, sq_done;
    logic [L_W-1:0]  sq_root;
    logic            div_start, div_done;
    logic [N_W-1:0]  div_num;
    logic [L_W-1:0]  div_den;
    logic [plar_pkg::Q_W-1:0] div_quo;
    logic [L_W-1:0]  div_rem;
    logic            more_edges;
    logic [CN_W-1:0] emit0_c, emit1_c, rest_c;

    assign iv = (step_interval == '0) ? IV_W'(1) : step_interval;
    assign eidx = (st_reg >= S_JOB) ? j_reg : k_reg;

    assign dx = {tx_reg[C_W-1], tx_reg} - {prev_x_reg[C_W-1], prev_x_reg};
    assign dy = {ty_reg[C_W-1], ty_reg} - {prev_y_reg[C_W-1], prev_y_reg};
    assign adx_c = dx[C_W] ? C_W'(-dx) : dx[C_W-1:0];
    assign ady_c = dy[C_W] ? C_W'(-dy) : dy[C_W-1:0];

    // First sample position on the edge; clamps to the edge start when the
    // carried distance already covers a whole interval.
    assign pos_c = ({1'b0, iv} > carry_reg) ? IV_W'({1'b0, iv} - carry_reg) : '0;

    always_comb begin
        mul_a = e_adx_reg[eidx];
        mul_b = e_adx_reg[eidx];
        unique case (st_reg)
            S_MY: begin
                mul_a = e_ady_reg[eidx];
                mul_b = e_ady_reg[eidx];
            end
            S_JMUL: begin
                mul_a = ph_reg[1] ? e_ady_reg[eidx] : e_adx_reg[eidx];
                mul_b = ph_reg[0] ? {1'b0, iv} : {1'b0, e_pos_reg[eidx]};
            end
            default: begin
                mul_a = e_adx_reg[eidx];
                mul_b = e_adx_reg[eidx];
            end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    assign sq_start = (st_reg == S_SQ);

    plar_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand (sq_reg),
        .done     (sq_done),
        .root     (sq_root)
    );

    always_comb begin
        if (st_reg == S_JDIV) begin
            div_start = 1'b1;
            div_num   = ph_reg[0] ? prod_reg
                                  : prod_reg + {{(N_W - L_W + 1){1'b0}}, e_len_reg[eidx][L_W-1:1]};
            div_den   = e_len_reg[eidx];
        end else begin
            div_start = (st_reg == S_SQW) && sq_done && (sq_root != '0)
                        && ({2'b00, pos_c} <= sq_root);
            div_num   = {{(N_W - L_W){1'b0}}, sq_root - {2'b00, pos_c}};
            div_den   = {2'b00, iv};
        end
    end

    plar_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo),
        .rem   (div_rem)
    );

    assign more_edges = !k_reg && cls_reg;

    // Clip both edges' sample counts to the per-vertex budget.
    always_comb begin
        emit0_c = (e_cnt_reg[0] > R_W'(MAX_OUT)) ? CN_W'(MAX_OUT) : e_cnt_reg[0][CN_W-1:0];
        rest_c  = CN_W'(MAX_OUT) - emit0_c;
        emit1_c = (e_cnt_reg[1] > R_W'(rest_c)) ? rest_c : e_cnt_reg[1][CN_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            st_reg      <= S_IDLE;
            prev_x_reg  <= '0;
            prev_y_reg  <= '0;
            start_x_reg <= '0;
            start_y_reg <= '0;
            carry_reg   <= '0;
            beg_reg     <= 1'b0;
            cls_reg     <= 1'b0;
            k_reg       <= 1'b0;
            j_reg       <= 1'b0;
            ph_reg      <= '0;
        end else begin
            unique case (st_reg)
                S_IDLE: begin
                    if (vertex_valid) begin
                        beg_reg <= begins_subpath;
                        cls_reg <= closes_subpath;
                        k_reg   <= 1'b0;
                        if (begins_subpath) begin
                            start_x_reg <= vertex_x;
                            start_y_reg <= vertex_y;
                            prev_x_reg  <= vertex_x;
                            prev_y_reg  <= vertex_y;
                            carry_reg   <= '0;
                            st_reg      <= S_FIN;
                        end else begin
                            st_reg <= S_EDGE;
                        end
                    end
                end
                S_EDGE: st_reg <= S_MX;
                S_MX:   st_reg <= S_MY;
                S_MY:   st_reg <= S_SQ;
                S_SQ:   st_reg <= S_SQW;
                S_SQW: begin
                    if (sq_done) begin
                        prev_x_reg <= tx_reg;
                        prev_y_reg <= ty_reg;
                        if (div_start) begin
                            st_reg <= S_QDW;
                        end else begin
                            if ((sq_root != '0) && ({2'b00, pos_c} > sq_root)) begin
                                carry_reg <= C_W'(carry_reg + sq_root);
                            end
                            if (more_edges) begin
                                k_reg  <= 1'b1;
                                st_reg <= S_EDGE;
                            end else begin
                                st_reg <= S_FIN;
                            end
                        end
                    end
                end
                S_QDW: begin
                    if (div_done) begin
                        carry_reg <= div_rem[C_W-1:0];
                        if (more_edges) begin
                            k_reg  <= 1'b1;
                            st_reg <= S_EDGE;
                        end else begin
                            st_reg <= S_FIN;
                        end
                    end
                end
                S_FIN: begin
                    j_reg  <= 1'b0;
                    st_reg <= S_JOB;
                end
                S_JOB: begin
                    ph_reg <= '0;
                    if (emit_reg[eidx] == '0) begin
                        if (j_reg) begin
                            st_reg <= S_IDLE;
                        end else begin
                            j_reg <= 1'b1;
                        end
                    end else if (beg_reg) begin
                        st_reg <= S_PUSH;
                    end else begin
                        st_reg <= S_JMUL;
                    end
                end
                S_JMUL: st_reg <= S_JDIV;
                S_JDIV: st_reg <= S_JDW;
                S_JDW: begin
                    if (div_done) begin
                        if (ph_reg == 2'd3) begin
                            st_reg <= S_PUSH;
                        end else begin
                            ph_reg <= ph_reg + 2'd1;
                            st_reg <= S_JMUL;
                        end
                    end
                end
                S_PUSH: begin
                    if (!full) begin
                        if (j_reg) begin
                            st_reg <= S_IDLE;
                        end else begin
                            j_reg  <= 1'b1;
                            st_reg <= S_JOB;
                        end
                    end
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end

    // Datapath registers; every one is written before it is read.
    always_ff @(posedge clk) begin
        priority if (st_reg == S_IDLE && vertex_valid) begin
            tx_reg       <= vertex_x;
            ty_reg       <= vertex_y;
            e_cnt_reg[1] <= '0;
            if (begins_subpath) begin
                e_px_reg[0]  <= vertex_x;
                e_py_reg[0]  <= vertex_y;
                e_nx_reg[0]  <= 1'b0;
                e_ny_reg[0]  <= 1'b0;
                e_len_reg[0] <= L_W'(1);
                e_cnt_reg[0] <= R_W'(1);
                for (int i = 0; i < 4; i++) begin
                    res_q_reg[i] <= '0;
                    res_r_reg[i] <= '0;
                end
            end
        end else if (st_reg == S_EDGE) begin
            e_px_reg[k_reg]  <= prev_x_reg;
            e_py_reg[k_reg]  <= prev_y_reg;
            e_adx_reg[k_reg] <= adx_c;
            e_ady_reg[k_reg] <= ady_c;
            e_nx_reg[k_reg]  <= dx[C_W];
            e_ny_reg[k_reg]  <= dy[C_W];
        end else if (st_reg == S_MX) begin
            sq_reg <= {1'b0, mul_p};
        end else if (st_reg == S_MY) begin
            sq_reg <= sq_reg + {1'b0, mul_p};
        end else if (st_reg == S_SQW && sq_done) begin
            e_len_reg[k_reg] <= sq_root;
            e_pos_reg[k_reg] <= pos_c;
            e_cnt_reg[k_reg] <= '0;
            if (more_edges) begin
                tx_reg <= start_x_reg;
                ty_reg <= start_y_reg;
            end
        end else if (st_reg == S_QDW && div_done) begin
            e_cnt_reg[k_reg] <= R_W'(div_quo) + R_W'(1);
            if (more_edges) begin
                tx_reg <= start_x_reg;
                ty_reg <= start_y_reg;
            end
        end else if (st_reg == S_FIN) begin
            emit_reg[0] <= emit0_c;
            emit_reg[1] <= emit1_c;
            trunc_reg   <= ({1'b0, e_cnt_reg[0]} + {1'b0, e_cnt_reg[1]}) > (R_W + 1)'(MAX_OUT);
        end else if (st_reg == S_JMUL) begin
            prod_reg <= mul_p;
        end else if (st_reg == S_JDW && div_done) begin
            res_q_reg[ph_reg] <= div_quo;
            res_r_reg[ph_reg] <= div_rem;
        end else begin
            sq_reg <= sq_reg;
        end
    end

    assign vertex_ready = (st_reg == S_IDLE);
    assign push = (st_reg == S_PUSH) && !full;

    always_comb begin
        job.px    = e_px_reg[eidx];
        job.py    = e_py_reg[eidx];
        job.negx  = e_nx_reg[eidx];
        job.negy  = e_ny_reg[eidx];
        job.qx    = res_q_reg[0];
        job.rx    = res_r_reg[0];
        job.bx    = res_q_reg[1];
        job.rbx   = res_r_reg[1];
        job.qy    = res_q_reg[2];
        job.ry    = res_r_reg[2];
        job.by    = res_q_reg[3];
        job.rby   = res_r_reg[3];
        job.len   = e_len_reg[eidx];
        job.cnt   = emit_reg[eidx];
        job.last  = j_reg || (emit_reg[1] == '0);
        job.trunc = trunc_reg;
    end

endmodule

`default_nettype wire

/* sv/plar_fifo.sv */
`default_nettype none

// Short job queue between the front and back ends.
module plar_fifo #(
    parameter int DEPTH = plar_pkg::FIFO_DEPTH
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire plar_pkg::job_t  wr_job,
    output logic                 full,
    input  wire logic            pop,
    output plar_pkg::job_t       rd_job,
    output logic                 empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    plar_pkg::job_t  mem_reg [DEPTH];
    logic [PW-1:0]   wp_reg, rp_reg;
    logic [PW:0]     cnt_reg;

    assign full   = (cnt_reg == (PW + 1)'(DEPTH));
    assign empty  = (cnt_reg == '0);
    assign rd_job = mem_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push && !full) begin
                wp_reg <= (wp_reg == PW'(DEPTH - 1)) ? '0 : wp_reg + PW'(1);
            end
            if (pop && !empty) begin
                rp_reg <= (rp_reg == PW'(DEPTH - 1)) ? '0 : rp_reg + PW'(1);
            end
            unique case ({push && !full, pop && !empty})
                2'b10:   cnt_reg <= cnt_reg + (PW + 1)'(1);
                2'b01:   cnt_reg <= cnt_reg - (PW + 1)'(1);
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

    always_ff @(posedge clk) begin
        if (push && !full) begin
            mem_reg[wp_reg] <= wr_job;
        end
    end

endmodule

`default_nettype wire

/* sv/plar_back.sv */
`default_nettype none

// Back end: walks one job at a time, one sample per cycle unless the sample
// channel stalls, with the output register in front of the sample channel.
module plar_back #(
    parameter int COORD_BITS = plar_pkg::COORD_BITS_DEFAULT
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              empty,
    input  wire plar_pkg::job_t                    rd_job,
    output logic                                   pop,
    input  wire logic signed [plar_pkg::C_W-1:0]   centre_x,
    input  wire logic signed [plar_pkg::C_W-1:0]   centre_y,
    output logic                                   sample_valid,
    input  wire logic                              sample_ready,
    output logic signed [plar_pkg::C_W-1:0]        sample_x,
    output logic signed [plar_pkg::C_W-1:0]        sample_y,
    output logic                                   last_of_run,
    output logic                                   truncated
);

    localparam int C_W = plar_pkg::C_W;
    localparam int W_W = C_W + 3;
    localparam int SW  = (COORD_BITS < C_W) ? COORD_BITS : C_W;
    localparam int HI_I = (1 << (SW - 1)) - 1;
    localparam logic signed [W_W-1:0] HI = W_W'(HI_I);
    localparam logic signed [W_W-1:0] LO = -HI - W_W'(1);

    plar_pkg::job_t job_reg;
    logic           act_reg;
    logic           out_valid_reg;
    logic signed [C_W-1:0] sx_reg, sy_reg;
    logic           last_reg, trunc_reg;

    logic adv;
    logic signed [W_W-1:0] vx, vy;
    logic [plar_pkg::LEN_W:0] sumx, sumy;

    function automatic logic signed [W_W-1:0] place(
        input logic signed [C_W-1:0]      p,
        input logic                       neg,
        input logic [plar_pkg::Q_W-1:0]   q,
        input logic signed [C_W-1:0]      c
    );
        logic signed [W_W-1:0] qs;
        qs = neg ? -$signed(W_W'(q)) : $signed(W_W'(q));
        return W_W'(p) + qs - W_W'(c);
    endfunction

    function automatic logic signed [C_W-1:0] sat(input logic signed [W_W-1:0] v);
        logic signed [W_W-1:0] r;
        r = (v > HI) ? HI : ((v < LO) ? LO : v);
        return r[C_W-1:0];
    endfunction

    assign vx = place(job_reg.px, job_reg.negx, job_reg.qx, centre_x);
    assign vy = place(job_reg.py, job_reg.negy, job_reg.qy, centre_y);
    assign sumx = {1'b0, job_reg.rx} + {1'b0, job_reg.rbx};
    assign sumy = {1'b0, job_reg.ry} + {1'b0, job_reg.rby};

    assign pop = !act_reg && !empty;
    assign adv = act_reg && (!out_valid_reg || sample_ready);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            act_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (pop) begin
                act_reg <= 1'b1;
            end else if (adv && job_reg.cnt == plar_pkg::JOB_CNT_W'(1)) begin
                act_reg <= 1'b0;
            end
            if (adv) begin
                out_valid_reg <= 1'b1;
            end else if (sample_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (pop) begin
            job_reg <= rd_job;
        end else if (adv) begin
            job_reg.cnt <= job_reg.cnt - plar_pkg::JOB_CNT_W'(1);
            if (sumx >= {1'b0, job_reg.len}) begin
                job_reg.rx <= plar_pkg::LEN_W'(sumx - {1'b0, job_reg.len});
                job_reg.qx <= job_reg.qx + job_reg.bx + plar_pkg::Q_W'(1);
            end else begin
                job_reg.rx <= sumx[plar_pkg::LEN_W-1:0];
                job_reg.qx <= job_reg.qx + job_reg.bx;
            end
            if (sumy >= {1'b0, job_reg.len}) begin
                job_reg.ry <= plar_pkg::LEN_W'(sumy - {1'b0, job_reg.len});
                job_reg.qy <= job_reg.qy + job_reg.by + plar_pkg::Q_W'(1);
            end else begin
                job_reg.ry <= sumy[plar_pkg::LEN_W-1:0];
                job_reg.qy <= job_reg.qy + job_reg.by;
            end
        end
        if (adv) begin
            sx_reg    <= sat(vx);
            sy_reg    <= sat(vy);
            last_reg  <= job_reg.last && (job_reg.cnt == plar_pkg::JOB_CNT_W'(1));
            trunc_reg <= job_reg.trunc;
        end
    end

    assign sample_valid = out_valid_reg;
    assign sample_x     = sx_reg;
    assign sample_y     = sy_reg;
    assign last_of_run  = last_reg;
    assign truncated    = trunc_reg;

endmodule

`default_nettype wire

/* sv/polyline_arc_length_resampler_unit.sv */
// A start vertex gives its sample; an edge vertex has each edge measured
// (square root, count division), then the interpolation set up for each
// emitting edge. One vertex is in flight in the front end; samples leave at
// one per cycle within a job unless the sample channel stalls. Reset (rst_n,
// async, low) clears the current point, subpath start, carried distance and
// queue, and restores the configuration defaults.
`default_nettype none

// The front end classifies each vertex and measures its edges with a shared
// multiplier, a bit-serial square root and a bit-serial divider. The sample
// count of every edge is known before any sample is released, so the
// truncated flag can be given on every beat of a run. Each emitting edge
// becomes a job in a short queue; the back end walks a job with a running
// quotient and remainder per axis, so the interpolation needs no per-sample
// division. The back end keeps an output register and the queue holds jobs,
// so a stalled sample channel stops the front end only once the queue is full.
module polyline_arc_length_resampler_unit #(
    parameter int MAX_OUT    = plar_pkg::MAX_OUT_DEFAULT,
    parameter int COORD_BITS = plar_pkg::COORD_BITS_DEFAULT
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   cfg_we,
    input  wire logic [plar_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [plar_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  wire logic                                   vertex_valid,
    output logic                                        vertex_ready,
    input  wire logic signed [plar_pkg::C_W-1:0]        vertex_x,
    input  wire logic signed [plar_pkg::C_W-1:0]        vertex_y,
    input  wire logic                                   begins_subpath,
    input  wire logic                                   closes_subpath,
    output logic                                        sample_valid,
    input  wire logic                                   sample_ready,
    output logic signed [plar_pkg::C_W-1:0]             sample_x,
    output logic signed [plar_pkg::C_W-1:0]             sample_y,
    output logic                                        last_of_run,
    output logic                                        truncated
);

    logic [plar_pkg::IV_W-1:0]        step_interval_reg;
    logic signed [plar_pkg::C_W-1:0]  centre_x_reg;
    logic signed [plar_pkg::C_W-1:0]  centre_y_reg;

    // Configuration writes land directly; the user must issue them only while idle, the block does not enforce it.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            step_interval_reg <= plar_pkg::STEP_INTERVAL_RESET;
            centre_x_reg      <= '0;
            centre_y_reg      <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                plar_pkg::REG_STEP_INTERVAL: step_interval_reg <= cfg_data[plar_pkg::IV_W-1:0];
                plar_pkg::REG_CENTRE_X:      centre_x_reg      <= cfg_data;
                plar_pkg::REG_CENTRE_Y:      centre_y_reg      <= cfg_data;
                default:                     centre_y_reg      <= centre_y_reg;
            endcase
        end
    end

    logic           push, full, pop, empty;
    plar_pkg::job_t wr_job, rd_job;

    plar_front #(
        .MAX_OUT (MAX_OUT)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .vertex_valid   (vertex_valid),
        .vertex_ready   (vertex_ready),
        .vertex_x       (vertex_x),
        .vertex_y       (vertex_y),
        .begins_subpath (begins_subpath),
        .closes_subpath (closes_subpath),
        .step_interval  (step_interval_reg),
        .push           (push),
        .job            (wr_job),
        .full           (full)
    );

    plar_fifo #(
        .DEPTH (plar_pkg::FIFO_DEPTH)
    ) u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_job (wr_job),
        .full   (full),
        .pop    (pop),
        .rd_job (rd_job),
        .empty  (empty)
    );

    plar_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .empty        (empty),
        .rd_job       (rd_job),
        .pop          (pop),
        .centre_x     (centre_x_reg),
        .centre_y     (centre_y_reg),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample_x     (sample_x),
        .sample_y     (sample_y),
        .last_of_run  (last_of_run),
        .truncated    (truncated)
    );

endmodule

`default_nettype wire

/* sv/plar_checker.sv */
`default_nettype none

`include "polyline_arc_length_resampler_unit_assert.svh"

// Watches the sample channel of the resampler.
module plar_checker #(
    parameter int MAX_OUT = plar_pkg::MAX_OUT_DEFAULT
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              sample_valid,
    input  wire logic                              sample_ready,
    input  wire logic signed [plar_pkg::C_W-1:0]   sample_x,
    input  wire logic signed [plar_pkg::C_W-1:0]   sample_y,
    input  wire logic                              last_of_run,
    input  wire logic                              truncated
);

    localparam int BW = $clog2(MAX_OUT + 1);

    // Beats already delivered in the current run.
    logic [BW-1:0] beats_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            beats_reg <= '0;
        end else if (sample_valid && sample_ready) begin
            beats_reg <= last_of_run ? '0 : beats_reg + BW'(1);
        end
    end

    `PLAR_ASSERT_NEXT(a_stall_holds, sample_valid && !sample_ready, sample_valid && $stable(sample_x) && $stable(sample_y) && $stable(last_of_run) && $stable(truncated))
    `PLAR_ASSERT_NOW(a_run_bounded, sample_valid && !last_of_run, beats_reg < BW'(MAX_OUT - 1))
    `PLAR_ASSERT_NOW(a_trunc_full, sample_valid && last_of_run && truncated, beats_reg == BW'(MAX_OUT - 1))
    `PLAR_ASSERT_NOW(a_quiet_after_reset, $rose(rst_n), !sample_valid)

endmodule

bind polyline_arc_length_resampler_unit plar_checker #(
    .MAX_OUT (MAX_OUT)
) u_plar_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample_x     (sample_x),
    .sample_y     (sample_y),
    .last_of_run  (last_of_run),
    .truncated    (truncated)
);

`default_nettype wire
